### hw/rtl/obpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obpc_pkg
// Shared types, constants and helpers of the oriented box point counter.
// ----------------------------------------------------------------------------
package obpc_pkg;

  localparam int MAX_POINTS    = 131072;
  localparam int COORD_BITS    = 16;
  localparam int ROT_FRAC_BITS = 14;

  localparam int ENTRY_W   = 16;
  localparam int PACK_W    = 3 * ENTRY_W;
  localparam int COUNT_W   = 18;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 3;

  localparam int DIFF_W  = COORD_BITS + 1;
  localparam int PROD_W  = ENTRY_W + DIFF_W;
  localparam int SUM_W   = PROD_W + 2;
  localparam int BOUND_W = ENTRY_W + ROT_FRAC_BITS + 1;
  localparam int ACC_W   = (SUM_W > BOUND_W) ? SUM_W : BOUND_W;

  localparam int QUEUE_DEPTH = 8;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [MODE_W-1:0] MODE_OFF      = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ELEVATOR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_GARAGE   = 2'd2;

  localparam logic [PACK_W-1:0] ROT_FIRST_RST  = 48'h0000_0000_4000;
  localparam logic [PACK_W-1:0] ROT_SECOND_RST = 48'h0000_4000_0000;
  localparam logic [PACK_W-1:0] ROT_THIRD_RST  = 48'h4000_0000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROT_FIRST  = 3'd0,
    CFG_ROT_SECOND = 3'd1,
    CFG_ROT_THIRD  = 3'd2,
    CFG_TARGET     = 3'd3,
    CFG_BOX_LOWER  = 3'd4,
    CFG_BOX_UPPER  = 3'd5,
    CFG_MIN_COUNT  = 3'd6,
    CFG_MODE       = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] point_z;
    logic                         last_point;
  } point_t;

  typedef struct packed {
    logic               inside_res;
    logic               frame_end;
    logic [COUNT_W-1:0] region_count;
    logic               has_obstacle;
    logic               elevator_hit;
  } result_t;

  typedef struct packed {
    logic [PACK_W-1:0]  rot_row_first;
    logic [PACK_W-1:0]  rot_row_second;
    logic [PACK_W-1:0]  rot_row_third;
    logic [PACK_W-1:0]  target_origin;
    logic [PACK_W-1:0]  box_lower;
    logic [PACK_W-1:0]  box_upper;
    logic [COUNT_W-1:0] min_count;
    logic [MODE_W-1:0]  region_mode;
  } cfg_t;

  // classified point handed from front to back
  typedef struct packed {
    logic in_box;
    logic last;
  } cls_t;

  function automatic logic signed [ENTRY_W-1:0] entry_of(input logic [PACK_W-1:0] w,
                                                         input int idx);
    return $signed(w[idx*ENTRY_W +: ENTRY_W]);
  endfunction

  function automatic logic mode_on(input logic [MODE_W-1:0] mode);
    return (mode == MODE_ELEVATOR) || (mode == MODE_GARAGE);
  endfunction

endpackage

### hw/rtl/oriented_box_point_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oriented_box_point_counter
// Counts lidar points inside an oriented box, reports per frame verdicts.
// Result path: offset, rotate and box test registers, queue, result register.
// Throughput: one point per cycle while credits remain; eight queue credits cover
// the credit loop. A held result stalls the input once nine points are waiting.
// Reset: asynchronous, clears registers to identity rotation, mode off.
// ----------------------------------------------------------------------------
module oriented_box_point_counter (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  obpc_pkg::point_t               point_i,
  output logic                           empty,
  input  logic                           pop,
  output obpc_pkg::result_t              result_o,
  input  logic                           cfg_we_i,
  input  logic [obpc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [obpc_pkg::PACK_W-1:0]    cfg_wdata_i
);

  obpc_pkg::cfg_t cfg;
  obpc_pkg::cls_t front_cls, queue_cls;
  logic           front_valid, queue_valid, queue_pop;

  obpc_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  obpc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .point_i      (point_i),
    .cfg_i        (cfg),
    .credit_ret_i (queue_pop),
    .cls_valid_o  (front_valid),
    .cls_o        (front_cls)
  );

  obpc_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (front_valid),
    .wr_data_i (front_cls),
    .rd_en_i   (queue_pop),
    .rd_data_o (queue_cls),
    .valid_o   (queue_valid)
  );

  obpc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cls_valid_i   (queue_valid),
    .cls_i         (queue_cls),
    .cls_pop_o     (queue_pop),
    .min_count_i   (cfg.min_count),
    .region_mode_i (cfg.region_mode),
    .empty         (empty),
    .pop           (pop),
    .result_o      (result_o)
  );

endmodule

### hw/rtl/obpc_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obpc_regs
// Configuration register file with a plain write port.
// ----------------------------------------------------------------------------
module obpc_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [obpc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [obpc_pkg::PACK_W-1:0]    cfg_wdata_i,
  output obpc_pkg::cfg_t                 cfg_o
);

  obpc_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (obpc_pkg::cfg_idx_e'(cfg_idx_i))
        obpc_pkg::CFG_ROT_FIRST:  cfg_d.rot_row_first   = cfg_wdata_i;
        obpc_pkg::CFG_ROT_SECOND: cfg_d.rot_row_second  = cfg_wdata_i;
        obpc_pkg::CFG_ROT_THIRD:  cfg_d.rot_row_third   = cfg_wdata_i;
        obpc_pkg::CFG_TARGET:     cfg_d.target_origin   = cfg_wdata_i;
        obpc_pkg::CFG_BOX_LOWER:  cfg_d.box_lower       = cfg_wdata_i;
        obpc_pkg::CFG_BOX_UPPER:  cfg_d.box_upper       = cfg_wdata_i;
        obpc_pkg::CFG_MIN_COUNT:  cfg_d.min_count       = cfg_wdata_i[obpc_pkg::COUNT_W-1:0];
        obpc_pkg::CFG_MODE:       cfg_d.region_mode     = cfg_wdata_i[obpc_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rot_row_first   <= obpc_pkg::ROT_FIRST_RST;
      cfg_q.rot_row_second  <= obpc_pkg::ROT_SECOND_RST;
      cfg_q.rot_row_third   <= obpc_pkg::ROT_THIRD_RST;
      cfg_q.target_origin   <= '0;
      cfg_q.box_lower       <= '0;
      cfg_q.box_upper       <= '0;
      cfg_q.min_count       <= '0;
      cfg_q.region_mode     <= obpc_pkg::MODE_OFF;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### hw/rtl/obpc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obpc_front
// Three stage geometry pipeline: offset, rotate, box test. Credit based
// admission so that every classified point finds room in the queue.
// ----------------------------------------------------------------------------
module obpc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  obpc_pkg::point_t    point_i,
  input  obpc_pkg::cfg_t      cfg_i,
  input  logic                credit_ret_i,
  output logic                cls_valid_o,
  output obpc_pkg::cls_t      cls_o
);

  localparam int DW = obpc_pkg::DIFF_W;
  localparam int PW = obpc_pkg::PROD_W;
  localparam int AW = obpc_pkg::ACC_W;
  localparam int FB = obpc_pkg::ROT_FRAC_BITS;

  logic accept;
  logic [obpc_pkg::QCNT_W-1:0] credits_q, credits_d;

  logic                 s1_valid_q, s2_valid_q, s3_valid_q;
  logic                 s1_last_q, s2_last_q;
  logic signed [DW-1:0] s1_diff_q [3];
  logic signed [DW-1:0] s1_diff_d [3];
  logic signed [PW-1:0] s2_prod_q [3][3];
  logic signed [PW-1:0] s2_prod_d [3][3];
  obpc_pkg::cls_t       s3_cls_q, s3_cls_d;

  logic [obpc_pkg::PACK_W-1:0] rows [3];
  logic [obpc_pkg::COORD_BITS-1:0] coords [3];

  assign rows[0]   = cfg_i.rot_row_first;
  assign rows[1]   = cfg_i.rot_row_second;
  assign rows[2]   = cfg_i.rot_row_third;
  assign coords[0] = point_i.point_x;
  assign coords[1] = point_i.point_y;
  assign coords[2] = point_i.point_z;

  assign full   = (credits_q == obpc_pkg::QCNT_W'(obpc_pkg::QUEUE_DEPTH));
  assign accept = push && !full;

  always_comb begin
    credits_d = credits_q;
    if (accept && !credit_ret_i) begin
      credits_d = credits_q + 1'b1;
    end else if (!accept && credit_ret_i) begin
      credits_d = credits_q - 1'b1;
    end
  end

  // offset from the target origin
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      s1_diff_d[a] = DW'($signed(coords[a])) -
                     DW'(obpc_pkg::entry_of(cfg_i.target_origin, a));
    end
  end

  // rotation products
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        s2_prod_d[r][c] = PW'(obpc_pkg::entry_of(rows[r], c)) * PW'(s1_diff_q[c]);
      end
    end
  end

  // box test on the exact sums
  always_comb begin
    logic signed [AW-1:0] acc;
    logic signed [AW-1:0] lo;
    logic signed [AW-1:0] hi;
    logic                 ok;
    ok = obpc_pkg::mode_on(cfg_i.region_mode);
    for (int r = 0; r < 3; r++) begin
      acc = AW'(s2_prod_q[r][0]) + AW'(s2_prod_q[r][1]) + AW'(s2_prod_q[r][2]);
      lo  = AW'($signed({obpc_pkg::entry_of(cfg_i.box_lower, r), {FB{1'b0}}}));
      hi  = AW'($signed({obpc_pkg::entry_of(cfg_i.box_upper, r), {FB{1'b0}}}));
      ok  = ok && (acc >= lo) && (acc <= hi);
    end
    s3_cls_d.in_box = ok;
    s3_cls_d.last   = s2_last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credits_q  <= '0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      credits_q  <= credits_d;
      s1_valid_q <= accept;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_diff_q <= s1_diff_d;
      s1_last_q <= point_i.last_point;
    end
    if (s1_valid_q) begin
      s2_prod_q <= s2_prod_d;
      s2_last_q <= s1_last_q;
    end
    if (s2_valid_q) begin
      s3_cls_q <= s3_cls_d;
    end
  end

  assign cls_valid_o = s3_valid_q;
  assign cls_o       = s3_cls_q;

endmodule

### hw/rtl/obpc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obpc_queue
// Small first-in first-out queue of classified points between front and back.
// ----------------------------------------------------------------------------
module obpc_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_en_i,
  input  obpc_pkg::cls_t wr_data_i,
  input  logic           rd_en_i,
  output obpc_pkg::cls_t rd_data_o,
  output logic           valid_o
);

  obpc_pkg::cls_t mem_q [obpc_pkg::QUEUE_DEPTH];

  logic [obpc_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [obpc_pkg::QCNT_W-1:0] cnt_q, cnt_d;

  assign valid_o   = (cnt_q != '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (wr_en_i && !rd_en_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!wr_en_i && rd_en_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (wr_en_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (rd_en_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

### hw/rtl/obpc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obpc_back
// Frame tally, obstacle and elevator verdicts, and the result register.
// ----------------------------------------------------------------------------
module obpc_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cls_valid_i,
  input  obpc_pkg::cls_t               cls_i,
  output logic                         cls_pop_o,
  input  logic [obpc_pkg::COUNT_W-1:0] min_count_i,
  input  logic [obpc_pkg::MODE_W-1:0]  region_mode_i,
  output logic                         empty,
  input  logic                         pop,
  output obpc_pkg::result_t            result_o
);

  localparam int CW = obpc_pkg::COUNT_W;

  logic              out_valid_q;
  obpc_pkg::result_t out_q, out_d;
  logic [CW-1:0]     tally_q, tally_d, count_now;

  assign empty     = !out_valid_q;
  assign cls_pop_o = cls_valid_i && (!out_valid_q || pop);

  always_comb begin
    count_now = tally_q;
    if (cls_i.in_box && (tally_q < CW'(obpc_pkg::MAX_POINTS))) begin
      count_now = tally_q + 1'b1;
    end
    out_d.inside_res   = cls_i.in_box;
    out_d.frame_end    = cls_i.last;
    out_d.region_count = count_now;
    out_d.has_obstacle = cls_i.last && obpc_pkg::mode_on(region_mode_i) &&
                         (count_now >= min_count_i);
    out_d.elevator_hit = cls_i.last && (region_mode_i == obpc_pkg::MODE_ELEVATOR) &&
                         (count_now != '0);
    tally_d = cls_i.last ? '0 : count_now;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      tally_q     <= '0;
    end else begin
      if (cls_pop_o) begin
        out_valid_q <= 1'b1;
        tally_q     <= tally_d;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cls_pop_o) begin
      out_q <= out_d;
    end
  end

  assign result_o = out_q;

endmodule

### hw/rtl/obpc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obpc_checker
// Port level checks of the oriented box point counter.
// ----------------------------------------------------------------------------
module obpc_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              empty,
  input logic              pop,
  input obpc_pkg::result_t result_o
);

  // verdicts only on the last point of a frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !result_o.frame_end) |->
      (!result_o.has_obstacle && !result_o.elevator_hit))
    else $error("frame verdict outside frame end");

  // an inside point or an elevator hit never shows a zero count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (result_o.inside_res || result_o.elevator_hit)) |->
      (result_o.region_count != '0))
    else $error("inside point with zero count");

  // no result is waiting straight out of reset
  assert property (@(posedge clk_i) $rose(rst_ni) |-> empty)
    else $error("result present after reset");

  // a waiting transaction holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(result_o)))
    else $error("waiting result changed");

endmodule

bind oriented_box_point_counter obpc_checker u_obpc_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .empty    (empty),
  .pop      (pop),
  .result_o (result_o)
);
